/* rtl/core/sai_pkg.sv */
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and codes for the sorted array insert/delete block.
// ----------------------------------------------------------------------------
package sai_pkg;

  // Data word held in each entry.
  typedef logic signed [31:0] word_t;

  // Operation requested by one item.
  typedef logic [1:0] op_t;

  // Result status code.
  typedef logic [1:0] status_t;

  // Read index as carried on the request channel.
  typedef logic [3:0] index_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_INSERT = 2'd2;
  localparam op_t OP_READ   = 2'd3;

  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_ABSENT = 2'd2;
  localparam status_t ST_RANGE  = 2'd3;

endpackage

/* rtl/core/sai_req_if.sv */
// ----------------------------------------------------------------------------
// sai_req_if
// Request channel: one operation item with its value and read index.
// ----------------------------------------------------------------------------
interface sai_req_if import sai_pkg::*; ();

  logic   valid;
  logic   ready;
  op_t    op;
  word_t  value;
  index_t index;

  modport source (output valid, output op, output value, output index, input ready);
  modport sink   (input valid, input op, input value, input index, output ready);

endinterface

/* rtl/core/sai_rsp_if.sv */
// ----------------------------------------------------------------------------
// sai_rsp_if
// Result channel: read data, entry count and status of one operation.
// ----------------------------------------------------------------------------
interface sai_rsp_if import sai_pkg::*; #(
  parameter int COUNT_W = 5
) ();

  logic               valid;
  logic               ready;
  word_t              read_value;
  logic [COUNT_W-1:0] count;
  status_t            status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink   (input valid, input read_value, input count, input status, output ready);

endinterface

/* rtl/core/sorted_array_insert_delete.sv */
// ----------------------------------------------------------------------------
// sorted_array_insert_delete
// Packed array of signed words with append, delete, ordered insert and read.
// ----------------------------------------------------------------------------
// The req channel carries one item per operation (op, value, index); the rsp
// channel returns one item per request: read_value (zero unless a read
// succeeds), the entry count after the operation, and a status code. The rsp
// count width must be clog2(DEPTH+1). req.ready is high only while the
// sequencer is idle, so requests are taken one at a time.
// Append, a refused insert and an out-of-range read go straight to the
// result state; an in-range read first passes the registered memory read;
// delete and insert first stream every held entry through the one-read,
// one-write entry memory and the one compare/shift unit. The sequencer is
// idle again once the result moves into the output register, so it takes
// no new request until it is through with the last. A new request is
// accepted while the previous result waits; if the receiver stalls, the
// next result is held until the output register frees.
// A synchronous reset empties the array (count zero) and drops any pending
// result. Entry contents are not cleared; they are never read before written.
// ----------------------------------------------------------------------------
module sorted_array_insert_delete import sai_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  sai_req_if.sink   req,
  sai_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] cnt;
  logic [CW-1:0] ptr;
  logic          dvalid;
  logic          found;
  word_t         hold;
  op_t           op_q;
  word_t         val_q;
  word_t         res_value;
  status_t       res_status;

  logic          out_valid;
  word_t         out_value;
  logic [CW-1:0] out_count;
  status_t       out_status;

  // Entry memory with registered read.
  word_t         mem [DEPTH];
  word_t         rd_data;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  word_t         wd;

  logic              take;
  logic              full;
  logic              issue;
  logic              scan_end;
  logic              less_eq;
  logic              idx_ok;
  logic [CW-1:0]     cur_idx;
  logic [CW-1:0]     prev_idx;
  logic [AW+3:0]     idx_ext;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.count      = out_count;
  assign rsp.status     = out_status;

  // Datapath control: memory addressing and the shared compare/shift unit.
  always_comb begin
    take     = req.valid && req.ready;
    full     = (cnt == CW'(DEPTH));
    idx_ext  = (AW + 4)'(req.index);
    idx_ok   = ((CW + 4)'(req.index) < (CW + 4)'(cnt));
    issue    = (state == S_SCAN) && (ptr < cnt);
    scan_end = (state == S_SCAN) && !issue && !dvalid;
    cur_idx  = ptr - CW'(1);
    prev_idx = ptr - CW'(2);
    less_eq  = (val_q <= rd_data);
    rd_addr  = (state == S_IDLE) ? idx_ext[AW-1:0] : ptr[AW-1:0];

    we = 1'b0;
    wa = cnt[AW-1:0];
    wd = req.value;
    if (take && (req.op == OP_APPEND) && !full) begin
      we = 1'b1;
      wa = cnt[AW-1:0];
      wd = req.value;
    end
    if ((state == S_SCAN) && dvalid) begin
      if (op_q == OP_DELETE) begin
        // After the match, every entry moves down by one.
        if (found) begin
          we = 1'b1;
          wa = prev_idx[AW-1:0];
          wd = rd_data;
        end
      end else if (found) begin
        // After the insertion point, every entry moves up by one.
        we = 1'b1;
        wa = cur_idx[AW-1:0];
        wd = hold;
      end else if (less_eq) begin
        we = 1'b1;
        wa = cur_idx[AW-1:0];
        wd = val_q;
      end
    end
    if (scan_end && (op_q == OP_INSERT)) begin
      we = 1'b1;
      wa = cnt[AW-1:0];
      wd = found ? hold : val_q;
    end
  end

  // Memory write and read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      ptr       <= '0;
      dvalid    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output register empties when its item is taken, unless a new
      // result moves in at the same edge.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            op_q       <= req.op;
            val_q      <= req.value;
            res_value  <= '0;
            ptr        <= '0;
            found      <= 1'b0;
            dvalid     <= 1'b0;
            case (req.op)
              OP_APPEND: begin
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_DONE;
                  cnt        <= cnt + CW'(1);
                end
                state <= S_DONE;
              end
              OP_DELETE: begin
                res_status <= ST_DONE;
                state      <= S_SCAN;
              end
              OP_INSERT: begin
                if (full) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  res_status <= ST_DONE;
                  state      <= S_SCAN;
                end
              end
              default: begin
                if (idx_ok) begin
                  res_status <= ST_DONE;
                  state      <= S_READ;
                end else begin
                  res_status <= ST_RANGE;
                  state      <= S_DONE;
                end
              end
            endcase
          end
        end
        S_READ: begin
          res_value <= rd_data;
          state     <= S_DONE;
        end
        S_SCAN: begin
          // Stream entries out of memory one per cycle.
          dvalid <= issue;
          if (issue) begin
            ptr <= ptr + CW'(1);
          end
          if (dvalid) begin
            if (op_q == OP_DELETE) begin
              if (!found && (rd_data == val_q)) begin
                found <= 1'b1;
              end
            end else if (found) begin
              hold <= rd_data;
            end else if (less_eq) begin
              found <= 1'b1;
              hold  <= rd_data;
            end
          end
          if (scan_end) begin
            if (op_q == OP_DELETE) begin
              if (found) begin
                cnt <= cnt - CW'(1);
              end else begin
                res_status <= ST_ABSENT;
              end
            end else begin
              cnt <= cnt + CW'(1);
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the result over once the output register is free.
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_count  <= cnt;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The count never exceeds the array depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  // An append into a non-full array grows the count by exactly one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (take && (req.op == OP_APPEND) && !full) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("append did not grow count");

  // Streamed data is only pending after a read was issued.
  a_dvalid_ptr: assert property (@(posedge clk) disable iff (rst)
    dvalid |-> ((ptr != '0) && (state == S_SCAN)))
    else $error("stream data without issued read");

  // A full status always reports a full array.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_FULL)) |-> (out_count == CW'(DEPTH)))
    else $error("full status with non-full count");

  // The memory is never written while the sequencer waits to deliver.
  a_no_write_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE || state == S_READ) |-> !we)
    else $error("memory write outside an active step");
`endif

endmodule
